// ----- rtl/core/rpcn_pkg.sv -----
// ----------------------------------------------------------------------------
// rpcn_pkg: shared types and constants of the RMS normalizer
// Item payload structs, register indexes, frame limits and the control and
// status structs between the sequencer and the shared divide/root unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rpcn_pkg;

  // Sample and field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgW    = 15;
  localparam int unsigned CntW    = 13;
  localparam int unsigned SumW    = 42;
  localparam int unsigned ScaleW  = 24;

  // Frame length limit: the smaller of the frame size and the counter range
  localparam int unsigned MaxFrameLen = 4096;
  localparam int unsigned CntLimit    = 8191;
  localparam int unsigned FrameCap    = (MaxFrameLen < CntLimit) ? MaxFrameLen : CntLimit;

  // Reset values
  localparam logic [CfgW-1:0]   TargetRst = 15'd8192;
  localparam logic [CfgW-1:0]   PeakCapRst = 15'd31130;
  localparam logic [ScaleW-1:0] ScaleOne  = 24'd65536;

  // Shared unit: operand widths
  localparam int unsigned NumW = 64;
  localparam int unsigned DenW = 32;

  // Item kinds
  localparam logic KindMeasure = 1'b0;
  localparam logic KindApply   = 1'b1;

  // Configuration register indexes
  localparam logic CfgTargetRms = 1'b0;
  localparam logic CfgPeakCap   = 1'b1;

  typedef enum logic {
    MODE_DIV,
    MODE_SQRT
  } unit_mode_e;

  typedef struct packed {
    logic                kind;
    logic signed [15:0]  sample;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0]  scaled_sample;
    logic                saturated;
  } out_item_t;

  typedef struct packed {
    logic       start;
    unit_mode_e mode;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/rpcn_divsqrt.sv -----
// ----------------------------------------------------------------------------
// rpcn_divsqrt: shared iterative divide / square-root unit
// Restoring division, one quotient bit per cycle, or
// digit-by-digit integer square root, one root bit per cycle.
// Both use the same shift, compare and subtract datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcn_divsqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rpcn_pkg::unit_ctl_t        ctl_i,
  input  logic [rpcn_pkg::NumW-1:0]  num_i,
  input  logic [rpcn_pkg::DenW-1:0]  den_i,
  output rpcn_pkg::unit_stat_t       stat_o,
  output logic [rpcn_pkg::NumW-1:0]  result_o
);
  import rpcn_pkg::*;

  logic             busy_q;
  logic             done_q;
  unit_mode_e       mode_q;
  logic [5:0]       cnt_q;
  logic [NumW-1:0]  acc_q;
  logic [DenW:0]    rem_q;
  logic [NumW-1:0]  res_q;
  logic [DenW-1:0]  den_q;

  logic [DenW+1:0]  rem_sh;
  logic [DenW+1:0]  trial;
  logic [DenW+1:0]  diff;
  logic             ge;

  // One step: bring in the next numerator bits, trial-subtract
  always_comb begin
    if (mode_q == MODE_SQRT) begin
      rem_sh = {rem_q[DenW-1:0], acc_q[NumW-1:NumW-2]};
      trial  = {res_q[DenW-1:0], 2'b01};
    end else begin
      rem_sh = {rem_q, acc_q[NumW-1]};
      trial  = {2'b00, den_q};
    end
    ge   = (rem_sh >= trial);
    diff = rem_sh - trial;
  end

  // Iteration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= MODE_DIV;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start && !busy_q) begin
        busy_q <= 1'b1;
        mode_q <= ctl_i.mode;
        cnt_q  <= (ctl_i.mode == MODE_SQRT) ? 6'd31 : 6'd63;
        acc_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        res_q  <= '0;
      end else if (busy_q) begin
        acc_q  <= (mode_q == MODE_SQRT) ? {acc_q[NumW-3:0], 2'b00}
                                        : {acc_q[NumW-2:0], 1'b0};
        rem_q  <= ge ? diff[DenW:0] : rem_sh[DenW:0];
        res_q  <= {res_q[NumW-2:0], ge};
        cnt_q  <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

// ----- rtl/core/rms_peak_capped_normaliser_top.sv -----
// ----------------------------------------------------------------------------
// rms_peak_capped_normaliser_top: frame RMS normalizer with peak limit
// Measure items accumulate sum of squares, peak and count; the last one
// derives a Q8.16 gain. Apply items return the sample times the gain,
// rounded and saturated.
//
//   Channel  | Signals                                  | Direction
//   ---------+------------------------------------------+----------
//   input    | in_valid_i, in_ready_o, in_item_i        | in
//   output   | out_valid_o, out_ready_i, out_item_o     | out
//   config   | cfg_valid_i, cfg_ready_o, cfg_index_i,   | in
//            | cfg_data_i                               |
//
// Measure and apply items each pass through the shared multiplier.
// The last measure item of a frame adds two 64-step divisions, a 32-step
// square root and a 64-step division for the peak cap in the shared
// divide/root unit, plus three sequencing steps. A silent frame skips the
// unit. An apply result waits in the output register; a further apply item
// stalls in its rounding step until that register is free.
// Reset sets the registers to their defaults, the gain to 1.0 and clears
// the accumulators. The config port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_peak_capped_normaliser_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rpcn_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rpcn_pkg::out_item_t           out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [rpcn_pkg::CfgW-1:0]     cfg_data_i
);
  import rpcn_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_RND,
    ST_FSTART,
    ST_DIV1,
    ST_SQRT,
    ST_DIV2,
    ST_CAP,
    ST_DIV3,
    ST_FEND
  } state_e;

  state_e              state_q;
  logic                kind_q;
  logic signed [15:0]  smp_q;
  logic                last_q;
  logic signed [41:0]  prod_q;
  logic [SumW-1:0]     sum_q;
  logic [15:0]         peak_q;
  logic [CntW-1:0]     cnt_q;
  logic [ScaleW-1:0]   gain_q;
  logic [ScaleW-1:0]   scale_q;
  logic [CfgW-1:0]     target_q;
  logic [CfgW-1:0]     pcap_q;
  logic                out_valid_q;
  out_item_t           out_item_q;

  unit_ctl_t           ctl_q;
  logic [NumW-1:0]     num_q;
  logic [DenW-1:0]     den_q;
  unit_stat_t          unit_stat;
  logic [NumW-1:0]     unit_res;

  logic signed [24:0]  mul_b;
  logic signed [41:0]  mul_p;
  logic [15:0]         smp_u;
  logic [15:0]         mag;
  logic [SumW:0]       sum_add;
  logic signed [41:0]  rnd_t;
  logic signed [25:0]  rnd_v;
  logic [ScaleW-1:0]   res_sat;

  rpcn_divsqrt u_divsqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_q),
    .num_i    (num_q),
    .den_i    (den_q),
    .stat_o   (unit_stat),
    .result_o (unit_res)
  );

  // Shared multiplier: square for measure, gain product for apply
  assign mul_b = (kind_q == KindApply) ? $signed({1'b0, gain_q})
                                       : $signed({{9{smp_q[15]}}, smp_q});
  assign mul_p = $signed({smp_q[15], smp_q}) * mul_b;

  // Magnitude and saturating sum of squares
  assign smp_u   = smp_q;
  assign mag     = smp_q[15] ? (~smp_u + 16'd1) : smp_u;
  assign sum_add = {1'b0, sum_q} + {12'd0, prod_q[30:0]};

  // Round to nearest, ties up, then arithmetic shift by 16
  assign rnd_t = prod_q + 42'sd32768;
  assign rnd_v = rnd_t[41:16];

  // Unit result clipped to the scale range
  assign res_sat = (|unit_res[NumW-1:ScaleW]) ? {ScaleW{1'b1}} : unit_res[ScaleW-1:0];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TargetRst;
      pcap_q   <= PeakCapRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgTargetRms: target_q <= cfg_data_i;
        CfgPeakCap:   pcap_q   <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      peak_q      <= '0;
      cnt_q       <= '0;
      gain_q      <= ScaleOne;
      out_valid_q <= 1'b0;
      ctl_q       <= '{start: 1'b0, mode: MODE_DIV};
    end else begin
      // start is a one-cycle pulse; it is never raised in the cycle after
      if (ctl_q.start) begin
        ctl_q.start <= 1'b0;
      end
      // the rounding step reloads the output register itself
      if (out_valid_q && out_ready_i && state_q != ST_RND) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            kind_q  <= in_item_i.kind;
            smp_q   <= in_item_i.sample;
            last_q  <= in_item_i.last;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= mul_p;
          state_q <= (kind_q == KindApply) ? ST_RND : ST_ACC;
        end
        ST_ACC: begin
          if (cnt_q < CntW'(FrameCap)) begin
            sum_q <= sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
            if (mag > peak_q) begin
              peak_q <= mag;
            end
            cnt_q <= cnt_q + 1'b1;
          end
          state_q <= last_q ? ST_FSTART : ST_IDLE;
        end
        ST_RND: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            if (rnd_v > 26'sd32767) begin
              out_item_q <= '{scaled_sample: 16'sh7fff, saturated: 1'b1};
            end else if (rnd_v < -26'sd32768) begin
              out_item_q <= '{scaled_sample: 16'sh8000, saturated: 1'b1};
            end else begin
              out_item_q <= '{scaled_sample: rnd_v[15:0], saturated: 1'b0};
            end
            state_q <= ST_IDLE;
          end
        end
        ST_FSTART: begin
          if (sum_q != '0 && cnt_q != '0) begin
            num_q   <= {2'b00, sum_q, 20'd0};
            den_q   <= {19'd0, cnt_q};
            ctl_q   <= '{start: 1'b1, mode: MODE_DIV};
            state_q <= ST_DIV1;
          end else begin
            scale_q <= ScaleOne;
            state_q <= ST_CAP;
          end
        end
        ST_DIV1: begin
          if (unit_stat.done) begin
            num_q   <= unit_res;
            ctl_q   <= '{start: 1'b1, mode: MODE_SQRT};
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (unit_stat.done) begin
            if (unit_res == '0) begin
              scale_q <= ScaleOne;
              state_q <= ST_CAP;
            end else begin
              num_q   <= {23'd0, target_q, 26'd0};
              den_q   <= unit_res[DenW-1:0];
              ctl_q   <= '{start: 1'b1, mode: MODE_DIV};
              state_q <= ST_DIV2;
            end
          end
        end
        ST_DIV2: begin
          if (unit_stat.done) begin
            scale_q <= res_sat;
            state_q <= ST_CAP;
          end
        end
        ST_CAP: begin
          if (peak_q != '0) begin
            num_q   <= {33'd0, pcap_q, 16'd0};
            den_q   <= {16'd0, peak_q};
            ctl_q   <= '{start: 1'b1, mode: MODE_DIV};
            state_q <= ST_DIV3;
          end else begin
            state_q <= ST_FEND;
          end
        end
        ST_DIV3: begin
          if (unit_stat.done) begin
            if (res_sat < scale_q) begin
              scale_q <= res_sat;
            end
            state_q <= ST_FEND;
          end
        end
        ST_FEND: begin
          gain_q  <= scale_q;
          sum_q   <= '0;
          peak_q  <= '0;
          cnt_q   <= '0;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  // Checks
  a_ready_unit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !unit_stat.busy)
    else $error("input ready while divide/root unit busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FrameCap))
    else $error("sample count beyond frame cap");

  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_stat.done |-> (state_q == ST_DIV1 || state_q == ST_SQRT ||
                        state_q == ST_DIV2 || state_q == ST_DIV3))
    else $error("unit finished with no step waiting for it");

endmodule

`default_nettype wire

// ----- tb/sv/rms_peak_capped_normaliser_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_peak_capped_normaliser_top_tb: self-checking bench for the RMS normalizer
// Feeds measure frames and apply samples over the valid/ready input, tracks
// the frame accumulators and the Q8.16 gain alongside the block, and checks
// every scaled sample and clip flag in order. Register settings change only
// while the block is quiet; both sides idle and stall at random.
// ----------------------------------------------------------------------------
module rms_peak_capped_normaliser_top_tb;
  import rpcn_pkg::*;

  localparam int unsigned     QuietCycles   = 400;
  localparam int unsigned     ItemsPerPhase = 480;
  localparam int unsigned     LongFrameLen  = 300;
  localparam int              MaxReported   = 10;
  localparam longint          SampleHi      = 2 ** (SampleW - 1) - 1;
  localparam longint          SampleLo      = -(2 ** (SampleW - 1));
  localparam longint unsigned SumMax        = (64'd1 << SumW) - 1;
  localparam longint unsigned ScaleMax      = (64'd1 << ScaleW) - 1;
  localparam logic signed [15:0] SmpMax     = 16'h7fff;
  localparam logic signed [15:0] SmpMin     = 16'h8000;
  localparam logic [CfgW-1:0] LevelTop      = 15'h7fff;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic            in_valid;
  logic            in_ready;
  in_item_t        in_item;
  logic            out_valid;
  logic            out_ready;
  out_item_t       out_item;
  logic            cfg_valid;
  logic            cfg_ready;
  logic            cfg_index;
  logic [CfgW-1:0] cfg_data;

  // Shadow of the block: levels, frame accumulators and held gain
  logic [CfgW-1:0] target_lvl;
  logic [CfgW-1:0] cap_lvl;
  longint unsigned frame_sq;
  longint unsigned frame_peak;
  longint unsigned frame_len;
  longint unsigned gain_q;
  out_item_t       scaled_expect_q[$];

  int in_idle_pct  = 13;
  int out_idle_pct = 51;
  int hold_left    = 0;

  int items_sent   = 0;
  int frames_done  = 0;
  int results_seen = 0;
  int clipped_seen = 0;
  int reg_writes   = 0;
  int mismatches   = 0;

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rms_peak_capped_normaliser_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Bitwise integer square root
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x    -= root + bitv;
        root  = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // End of frame: gain from RMS, limited by the peak cap, then clear
  function automatic void close_frame();
    longint unsigned scale;
    longint unsigned root;
    longint unsigned cap;
    longint unsigned lvl;
    scale = ScaleOne;
    if (frame_sq != 0 && frame_len != 0) begin
      root = int_sqrt((frame_sq << 20) / frame_len);
      lvl  = target_lvl;
      if (root != 0) scale = (lvl << 26) / root;
    end
    if (frame_peak != 0) begin
      lvl = cap_lvl;
      cap = (lvl << 16) / frame_peak;
      if (cap < scale) scale = cap;
    end
    gain_q     = (scale > ScaleMax) ? ScaleMax : scale;
    frame_sq   = 0;
    frame_peak = 0;
    frame_len  = 0;
    frames_done++;
  endfunction

  // Accepted item: accumulate a measure sample or predict a scaled sample
  function automatic void track_item(in_item_t it);
    longint          smp;
    longint          prod;
    longint          q;
    longint unsigned mag;
    out_item_t       want;
    smp = $signed(it.sample);
    if (it.kind == KindMeasure) begin
      if (frame_len < FrameCap) begin
        mag = (smp < 0) ? -smp : smp;
        frame_sq = (frame_sq > SumMax - mag * mag) ? SumMax : frame_sq + mag * mag;
        if (mag > frame_peak) frame_peak = mag;
        frame_len++;
      end
      if (it.last) close_frame();
    end else begin
      prod = smp * longint'(gain_q);
      // round half up, then clip
      q = (prod + 32768) >>> 16;
      want.saturated = 1'b0;
      if (q > SampleHi) begin
        q = SampleHi;
        want.saturated = 1'b1;
      end
      if (q < SampleLo) begin
        q = SampleLo;
        want.saturated = 1'b1;
      end
      want.scaled_sample = q[15:0];
      scaled_expect_q.push_back(want);
    end
  endfunction

  function automatic logic signed [15:0] rand_sample(int unsigned amp_log);
    int v;
    case ($urandom_range(31))
      0: v = $urandom_range(1) ? int'(SampleHi) : int'(SampleLo);
      1: v = int'($urandom_range(2)) - 1;
      default: v = int'($urandom_range((1 << (amp_log + 1)) - 1)) - (1 << amp_log);
    endcase
    return v[15:0];
  endfunction

  function automatic logic [CfgW-1:0] pick_level();
    case ($urandom_range(9))
      0: return '0;
      1: return LevelTop;
      2: return 15'd1;
      default: return CfgW'($urandom_range(LevelTop));
    endcase
  endfunction

  // Result sink: checks each transfer, drives ready with stalls and hold-offs
  initial begin : result_sink
    out_item_t want;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && out_ready) begin
        results_seen++;
        if (out_item.saturated) clipped_seen++;
        if (scaled_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display("%0t: unexpected result: sample %0d sat %0b", $time,
                     $signed(out_item.scaled_sample), out_item.saturated);
        end else begin
          want = scaled_expect_q.pop_front();
          if (out_item.scaled_sample !== want.scaled_sample ||
              out_item.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= MaxReported)
              $display("%0t: mismatch: expected sample %0d sat %0b, got sample %0d sat %0b",
                       $time, $signed(want.scaled_sample), want.saturated,
                       $signed(out_item.scaled_sample), out_item.saturated);
          end
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // One input transfer; valid stays up between back-to-back items
  task automatic send_item(logic kind, logic signed [15:0] smp, logic lst);
    in_item_t it;
    it.kind   = kind;
    it.sample = smp;
    it.last   = lst;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    track_item(it);
    items_sent++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (scaled_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // Drained and past any gain computation still running
  task automatic settle();
    wait_results();
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CfgW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == CfgTargetRms) target_lvl = val;
    else cap_lvl = val;
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic set_levels(logic [CfgW-1:0] tgt, logic [CfgW-1:0] cap);
    settle();
    write_reg(CfgTargetRms, tgt);
    write_reg(CfgPeakCap, cap);
  endtask

  // Before any frame the gain is unity; last is ignored on apply items
  task automatic test_unity_gain();
    send_item(KindApply, SmpMin, 1'b0);
    send_item(KindApply, SmpMax, 1'b1);
    send_item(KindApply, 16'sd0, 1'b0);
    send_item(KindApply, -16'sd1, 1'b1);
  endtask

  task automatic test_gain_corners();
    // silent frame: gain stays at unity
    send_item(KindMeasure, 16'sd0, 1'b0);
    send_item(KindMeasure, 16'sd0, 1'b1);
    send_item(KindApply, 16'sd12345, 1'b0);
    // tiny frame at full levels: gain clips at the top of Q8.16
    set_levels(LevelTop, LevelTop);
    send_item(KindMeasure, 16'sd1, 1'b1);
    send_item(KindApply, 16'sd1, 1'b0);
    send_item(KindApply, -16'sd1, 1'b0);
    send_item(KindApply, 16'sd300, 1'b0);
    send_item(KindApply, SmpMin, 1'b0);
    // loud peak: the cap wins over the RMS gain
    send_item(KindMeasure, 16'sd100, 1'b0);
    send_item(KindMeasure, 16'sd100, 1'b0);
    send_item(KindMeasure, -16'sd30000, 1'b1);
    send_item(KindApply, 16'sd30000, 1'b0);
    send_item(KindApply, -16'sd30000, 1'b0);
    // gain of one half: ties round toward positive
    set_levels(LevelTop, 15'd1);
    send_item(KindMeasure, 16'sd2, 1'b1);
    send_item(KindApply, -16'sd1, 1'b0);
    send_item(KindApply, 16'sd1, 1'b0);
    send_item(KindApply, -16'sd3, 1'b0);
    send_item(KindApply, 16'sd3, 1'b0);
    // zero target mutes the output
    set_levels('0, LevelTop);
    send_item(KindMeasure, 16'sd1000, 1'b1);
    send_item(KindApply, SmpMax, 1'b0);
  endtask

  // Long frame of full-scale samples, then random samples and a last mark
  task automatic test_long_frame();
    set_levels(TargetRst, PeakCapRst);
    repeat (LongFrameLen) send_item(KindMeasure, SmpMin, 1'b0);
    repeat (4) send_item(KindMeasure, rand_sample(15), 1'b0);
    send_item(KindMeasure, rand_sample(15), 1'b1);
    send_item(KindApply, SmpMax, 1'b0);
    send_item(KindApply, SmpMin, 1'b0);
    send_item(KindApply, rand_sample(15), 1'b0);
  endtask

  // Receiver holds off long enough for the input to back up
  task automatic test_backpressure();
    int n;
    wait_results();
    hold_left = 300;
    for (n = 0; n < 4; n++) send_item(KindMeasure, rand_sample(12), n == 3);
    for (n = 0; n < 40; n++)
      send_item(KindApply, rand_sample(15), 1'($urandom_range(1)));
    wait_results();
  endtask

  // One random burst: mostly a well-formed frame followed by apply items
  task automatic send_burst(output int unsigned count);
    int unsigned pick;
    int unsigned len;
    int unsigned amp;
    int unsigned i;
    logic        quiet;
    pick  = $urandom_range(99);
    amp   = $urandom_range(15);
    quiet = ($urandom_range(19) == 0);
    count = 0;
    if (pick < 80) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(80, 13) : $urandom_range(12, 1);
      for (i = 1; i <= len; i++) begin
        if ($urandom_range(9) == 0) begin
          send_item(KindApply, rand_sample(15), 1'($urandom_range(1)));
          count++;
        end
        send_item(KindMeasure, quiet ? 16'sd0 : rand_sample(amp), i == len);
        count++;
      end
      len = $urandom_range(10, 1);
      for (i = 0; i < len; i++)
        send_item(KindApply, rand_sample($urandom_range(15)), 1'($urandom_range(1)));
      count += len;
    end else if (pick < 95) begin
      // noise: any kind, any last flag
      len = $urandom_range(8, 1);
      for (i = 0; i < len; i++)
        send_item(1'($urandom_range(1)), rand_sample(amp), 1'($urandom_range(1)));
      count += len;
    end else begin
      // unterminated frame: runs on into the next one
      len = $urandom_range(6, 1);
      for (i = 0; i < len; i++) send_item(KindMeasure, rand_sample(amp), 1'b0);
      send_item(KindApply, rand_sample(15), 1'b0);
      count += len + 1;
    end
    // now and then the sender waits out every pending result
    if ($urandom_range(19) == 0) wait_results();
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned sent;
    int unsigned next_cfg;
    int unsigned burst;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_idle_pct  = 13;
          out_idle_pct = 51;
        end
        1: begin
          in_idle_pct  = 51;
          out_idle_pct = 13;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      sent     = 0;
      next_cfg = 0;
      while (sent < ItemsPerPhase) begin
        if (sent >= next_cfg) begin
          set_levels(pick_level(), pick_level());
          next_cfg = sent + 100 + $urandom_range(100);
        end
        send_burst(burst);
        sent += burst;
      end
    end
  endtask

  // Main sequence
  initial begin : stimulus
    rst_ni     <= 1'b0;
    in_valid   <= 1'b0;
    in_item    <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CfgTargetRms;
    cfg_data   <= '0;
    target_lvl  = TargetRst;
    cap_lvl     = PeakCapRst;
    frame_sq    = 0;
    frame_peak  = 0;
    frame_len   = 0;
    gain_q      = ScaleOne;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_unity_gain();
    test_gain_corners();
    test_long_frame();
    test_backpressure();
    test_random_traffic();
    settle();

    $display("summary: %0d items in, %0d frames closed, %0d results checked (%0d clipped)",
             items_sent, frames_done, results_seen, clipped_seen);
    $display("summary: %0d register writes, %0d mismatches", reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
